### src/window_average_and_peak_macros.svh
// Assertion macros for the window average and peak RTL.
`ifndef WINDOW_AVERAGE_AND_PEAK_MACROS_SVH
`define WINDOW_AVERAGE_AND_PEAK_MACROS_SVH

`ifndef SYNTH
// Check cons in the same cycle as ante.
`define WAP_ASSERT_IMM(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// Check cons in the cycle after ante.
`define WAP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define WAP_ASSERT_IMM(label, clk, rst, ante, cons)
`define WAP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### src/wap_pkg.sv
// Types and constants for the window average and peak block.
package wap_pkg;

   localparam int DATA_W     = 32;
   localparam int PEAK_W     = 31;
   localparam int WINDOW_DEF = 256;

   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] sample;
   } wap_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] current_value;
      logic signed [DATA_W-1:0] mean_value;
      logic        [PEAK_W-1:0] peak_value;
   } wap_rsp_type;

   typedef struct packed {
      logic busy;
      logic valid;
   } wap_div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OLD_RD,
      ST_WRITE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV_WAIT,
      ST_RESP
   } wap_state_type;

endpackage

### src/wap_store.sv
// Sample ring memory: one write port, one read port, registered read data.
module wap_store import wap_pkg::*; #(
   parameter int DEPTH = WINDOW_DEF,
   parameter int IDX_W = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/wap_div.sv
// Serial signed divider: one quotient bit per cycle, truncates toward zero.
module wap_div import wap_pkg::*; #(
   parameter int SUM_W = 41,
   parameter int CNT_W = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic        [CNT_W-1:0]  divisor,
   output wap_div_stat_type         stat,
   output logic signed [DATA_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W);

   logic              busy_ff,  busy_in;
   logic              valid_ff, valid_in;
   logic              neg_ff,   neg_in;
   logic [CNT_W-1:0]  dvs_ff,   dvs_in;
   logic [CNT_W-1:0]  rem_ff,   rem_in;
   logic [SUM_W-1:0]  quo_ff,   quo_in;
   logic [STEP_W-1:0] cnt_ff,   cnt_in;
   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    diff;
   logic              ge;
   logic [DATA_W-1:0] mag_low;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in  = busy_ff;
      valid_in = valid_ff;
      neg_in   = neg_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         busy_in  = 1'b1;
         valid_in = 1'b0;
         neg_in   = dividend[SUM_W-1];
         dvs_in   = divisor;
         rem_in   = '0;
         quo_in   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         cnt_in   = STEP_W'(SUM_W - 1);
      end else if (busy_ff) begin
         rem_in = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   // The mean always fits 32 bits, so negate only the low word.
   assign mag_low    = quo_ff[DATA_W-1:0];
   assign quotient   = neg_ff ? signed'(-mag_low) : signed'(mag_low);
   assign stat.busy  = busy_ff;
   assign stat.valid = valid_ff;

endmodule

### src/window_average_and_peak.sv
// Top level of the sliding window average and peak block.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | wap_req_type: req_type, sample
//  rsp     | out       | rsp_valid / rsp_ready  | wap_rsp_type: current, mean, peak
//
// A record item runs through ST_OLD_RD (when the window is full), ST_WRITE,
// ST_SCAN of the fill_count entries after the write, ST_DRAIN, ST_DIV_WAIT, ST_RESP.
// The peak scan reads one entry per cycle from the single read port of the
// sample memory, and the divider runs alongside it.
// A clear item goes straight to ST_RESP. One item is in flight at a time.
// Reset clears head, fill count and running sum; the memory is not swept.
// The result waits in an output register, so a stalled rsp side holds only
// the final step; req_ready is high again once the result is loaded.
`include "window_average_and_peak_macros.svh"
module window_average_and_peak import wap_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  wap_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output wap_rsp_type rsp_data
);

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = DATA_W + CNT_W;

   wap_state_type            state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [DATA_W-1:0] sample_ff, sample_in;
   logic                     clr_ff, clr_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic                     scan_vld_ff, scan_vld_in;
   logic signed [DATA_W-1:0] best_ff, best_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   wap_rsp_type              rsp_data_ff, rsp_data_in;

   logic                     req_take;
   logic                     clr_take;
   logic                     window_empty;
   logic                     full;
   logic                     scan_last;
   logic [CNT_W-1:0]         fill_m1;
   logic                     rsp_load;
   logic signed [SUM_W-1:0]  old_ext;
   logic signed [SUM_W-1:0]  new_ext;

   logic                     st_wr_en;
   logic                     st_rd_en;
   logic [IDX_W-1:0]         st_rd_addr;
   logic signed [DATA_W-1:0] st_rd_data;

   logic                     div_start;
   wap_div_stat_type         div_stat;
   logic signed [DATA_W-1:0] div_quot;

   assign req_take     = req_valid && req_ready;
   assign clr_take     = req_take && (req_data.req_type == REQ_CLEAR);
   assign window_empty = (fill_ff == '0) && (head_ff == '0) && (sum_ff == '0);
   assign full         = fill_ff == CNT_W'(WINDOW);
   assign fill_m1      = fill_ff - 1'b1;
   assign scan_last    = CNT_W'(scan_idx_ff) == fill_m1;
   assign old_ext      = signed'({{CNT_W{st_rd_data[DATA_W-1]}}, st_rd_data});
   assign new_ext      = signed'({{CNT_W{sample_ff[DATA_W-1]}}, sample_ff});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type == REQ_CLEAR) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = full ? ST_OLD_RD : ST_WRITE;
               end
            end
         end
         ST_OLD_RD:   state_in = ST_WRITE;
         ST_WRITE:    state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_stat.valid) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Control outputs per state.
   always_comb begin
      req_ready  = 1'b0;
      st_wr_en   = 1'b0;
      st_rd_en   = 1'b0;
      st_rd_addr = head_ff;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         // Fetch the entry about to be overwritten so it leaves the sum.
         ST_OLD_RD: st_rd_en = 1'b1;
         ST_WRITE:  st_wr_en = 1'b1;
         ST_SCAN: begin
            st_rd_en   = 1'b1;
            st_rd_addr = scan_idx_ff;
            // Kick off the divide on the first scan cycle; sum and fill are final.
            div_start  = scan_idx_ff == '0;
         end
         ST_RESP:   rsp_load = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   // Datapath next values.
   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      clr_in       = clr_ff;
      scan_idx_in  = scan_idx_ff;
      scan_vld_in  = state_ff == ST_SCAN;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (req_take) begin
         sample_in = req_data.sample;
         clr_in    = req_data.req_type == REQ_CLEAR;
         if (req_data.req_type == REQ_CLEAR) begin
            head_in = '0;
            fill_in = '0;
            sum_in  = '0;
         end
      end

      if (state_ff == ST_WRITE) begin
         sum_in      = sum_ff - (full ? old_ext : '0) + new_ext;
         head_in     = (head_ff == IDX_W'(WINDOW - 1)) ? '0 : head_ff + 1'b1;
         fill_in     = full ? fill_ff : fill_ff + 1'b1;
         scan_idx_in = '0;
         best_in     = '0;
      end

      if (state_ff == ST_SCAN) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      // Compare read data in the cycle after its address.
      if (scan_vld_ff && (st_rd_data > best_ff)) begin
         best_in = st_rd_data;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (clr_ff) begin
            rsp_data_in = '0;
         end else begin
            rsp_data_in.current_value = sample_ff;
            rsp_data_in.mean_value    = div_quot;
            rsp_data_in.peak_value    = best_ff[PEAK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      clr_ff      <= clr_in;
      scan_idx_ff <= scan_idx_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   wap_store #(
      .DEPTH (WINDOW),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (head_ff),
      .wr_data (sample_ff),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   wap_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   `WAP_ASSERT_IMM(a_fill_max, clock, reset, 1'b1, fill_ff <= CNT_W'(WINDOW))
   `WAP_ASSERT_IMM(a_head_range, clock, reset, 1'b1, head_ff <= IDX_W'(WINDOW - 1))
   `WAP_ASSERT_NXT(a_clear_empties, clock, reset, clr_take, window_empty)
   `WAP_ASSERT_IMM(a_div_idle_start, clock, reset, div_start, !div_stat.busy && fill_ff != '0)

endmodule
